// ----- rtl/core/sha256_message_hasher_core_assert.svh -----
// Assertion macros for the SHA-256 message hasher core checks.
`ifndef SHA256_MESSAGE_HASHER_CORE_ASSERT_SVH
`define SHA256_MESSAGE_HASHER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SMH_ASSERT_NOW(lbl, ck, rn, pre, post) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (pre) |-> (post)) \
		else $error("sha256 core check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SMH_ASSERT_NEXT(lbl, ck, rn, pre, post) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (pre) |=> (post)) \
		else $error("sha256 core check failed");

`endif

// ----- rtl/core/sha256mh_pkg.sv -----
// Shared types, constants and SHA-256 helper functions.
`timescale 1ns / 1ps
`default_nettype none
package sha256mh_pkg;

	typedef logic [7:0][31:0] work_t;

	localparam int BLOCK_BYTES = 64;
	localparam int BLOCK_BITS  = BLOCK_BYTES * 8;

	localparam logic [7:0] PAD_MARK = 8'h80;
	localparam logic [5:0] LEN_FILL = 6'd56;
	localparam logic [5:0] FILL_LAST = 6'(BLOCK_BYTES - 1);

	localparam work_t H_INIT = {
		32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
		32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
	};

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] bsig0(input logic [31:0] x);
		bsig0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [31:0] bsig1(input logic [31:0] x);
		bsig1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic logic [31:0] ssig0(input logic [31:0] x);
		ssig0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic logic [31:0] ssig1(input logic [31:0] x);
		ssig1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
	endfunction

	function automatic logic [31:0] choose(input logic [31:0] x, input logic [31:0] y,
			input logic [31:0] z);
		choose = (x & y) ^ (~x & z);
	endfunction

	function automatic logic [31:0] majority(input logic [31:0] x, input logic [31:0] y,
			input logic [31:0] z);
		majority = (x & y) ^ (x & z) ^ (y & z);
	endfunction

endpackage
`default_nettype wire

// ----- rtl/core/sha256mh_round.sv -----
// One SHA-256 compression round over the eight working variables.
`timescale 1ns / 1ps
`default_nettype none
module sha256mh_round
	import sha256mh_pkg::*;
(
	input  work_t       v,
	input  logic [31:0] w_word,
	input  logic [31:0] k_word,
	output work_t       v_next
);

	logic [31:0] t1;
	logic [31:0] t2;

	assign t1 = v[7] + bsig1(v[4]) + choose(v[4], v[5], v[6]) + k_word + w_word;
	assign t2 = bsig0(v[0]) + majority(v[0], v[1], v[2]);

	always_comb begin
		v_next[7] = v[6];
		v_next[6] = v[5];
		v_next[5] = v[4];
		v_next[4] = v[3] + t1;
		v_next[3] = v[2];
		v_next[2] = v[1];
		v_next[1] = v[0];
		v_next[0] = t1 + t2;
	end

endmodule
`default_nettype wire

// ----- rtl/core/sha256_message_hasher_core.sv -----
// Top level of the SHA-256 message hasher core.
`timescale 1ns / 1ps
`default_nettype none
// SHA-256 over a byte stream. Each accepted item carries at most one message
// byte; bytes shift into a 512-bit block register that also serves as the
// message schedule window. Every 64th byte starts a compression that runs
// one round per cycle in a single round unit, 64 rounds and then a finish
// step that folds the working variables into the chaining words. An item
// with end_of_message pushes the padding (9 to 72 bytes) one byte per cycle,
// pausing while a compression runs, with one or two compressions, then
// offers the digest as eight beats, word 0 first, last_word on word 7.
// item_ready is high only while the core is idle, never while the digest is
// being delivered.
module sha256_message_hasher_core
	import sha256mh_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic [7:0]  data_byte,
	input  logic        byte_present,
	input  logic        end_of_message,
	output logic        digest_valid,
	input  logic        digest_ready,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_PAD,
		S_ROUND,
		S_FINISH,
		S_OUT
	} state_t;

	typedef enum logic [1:0] {
		P_MARK,
		P_ZERO,
		P_LEN
	} pad_t;

	state_t                state_q;
	pad_t                  pad_q;
	logic [2:0]            len_idx_q;
	logic                  end_q;
	logic                  done_q;
	logic [5:0]            fill_q;
	logic [60:0]           count_q;
	logic [BLOCK_BITS-1:0] buf_q;
	work_t                 v_q;
	work_t                 h_q;
	logic [5:0]            round_q;
	logic [2:0]            out_idx_q;

	logic        item_fire;
	logic        digest_fire;
	logic        len_mode;
	logic [63:0] len_shifted;
	logic [7:0]  pad_byte;
	logic        push;
	logic [7:0]  push_byte;
	logic        start_block;
	logic [31:0] w_next;
	work_t       v_next;

	assign item_ready   = (state_q == S_IDLE);
	assign digest_valid = (state_q == S_OUT);
	assign item_fire    = item_valid & item_ready;
	assign digest_fire  = digest_valid & digest_ready;

	assign digest_word = h_q[out_idx_q];
	assign word_index  = out_idx_q;
	assign last_word   = (out_idx_q == 3'd7);

	// Length bytes go out once the zero run has reached the length offset.
	assign len_mode    = (pad_q == P_LEN) || ((pad_q == P_ZERO) && (fill_q == LEN_FILL));
	assign len_shifted = {count_q, 3'b000} >> {~len_idx_q, 3'b000};

	always_comb begin
		if (pad_q == P_MARK) begin
			pad_byte = PAD_MARK;
		end else if (len_mode) begin
			pad_byte = len_shifted[7:0];
		end else begin
			pad_byte = 8'h00;
		end
	end

	assign push        = (item_fire && byte_present) || (state_q == S_PAD);
	assign push_byte   = (state_q == S_PAD) ? pad_byte : data_byte;
	assign start_block = push && (fill_q == FILL_LAST);

	// Schedule taps: the top word, buf_q[511:480], is w[t], the next one down is w[t+1], and so on.
	assign w_next = ssig1(buf_q[63:32]) + buf_q[223:192] + ssig0(buf_q[479:448])
		+ buf_q[511:480];

	sha256mh_round u_round (
		.v      (v_q),
		.w_word (buf_q[511:480]),
		.k_word (ROUND_K[round_q]),
		.v_next (v_next)
	);

	always_ff @(posedge clk) begin
		if (state_q == S_ROUND) begin
			buf_q <= {buf_q[BLOCK_BITS-33:0], w_next};
			v_q   <= v_next;
		end else begin
			if (push) begin
				buf_q <= {buf_q[BLOCK_BITS-9:0], push_byte};
			end
			if (start_block) begin
				v_q <= h_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			pad_q     <= P_MARK;
			len_idx_q <= 3'd0;
			end_q     <= 1'b0;
			done_q    <= 1'b0;
			fill_q    <= 6'd0;
			count_q   <= 61'd0;
			h_q       <= H_INIT;
			round_q   <= 6'd0;
			out_idx_q <= 3'd0;
		end else begin
			if (push) begin
				fill_q <= fill_q + 6'd1;
			end
			case (state_q)
				S_IDLE: begin
					if (item_fire) begin
						if (byte_present) begin
							count_q <= count_q + 61'd1;
						end
						end_q <= end_of_message;
						pad_q <= P_MARK;
						if (start_block) begin
							round_q <= 6'd0;
							state_q <= S_ROUND;
						end else if (end_of_message) begin
							state_q <= S_PAD;
						end
					end
				end
				S_PAD: begin
					if (pad_q == P_MARK) begin
						pad_q <= P_ZERO;
					end else if (len_mode) begin
						pad_q     <= P_LEN;
						len_idx_q <= len_idx_q + 3'd1;
						if (len_idx_q == 3'd7) begin
							done_q <= 1'b1;
						end
					end
					if (start_block) begin
						round_q <= 6'd0;
						state_q <= S_ROUND;
					end
				end
				S_ROUND: begin
					round_q <= round_q + 6'd1;
					if (round_q == 6'(BLOCK_BYTES - 1)) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					for (int i = 0; i < 8; i++) begin
						h_q[i] <= h_q[i] + v_q[i];
					end
					out_idx_q <= 3'd0;
					if (done_q) begin
						state_q <= S_OUT;
					end else if (end_q) begin
						state_q <= S_PAD;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_OUT: begin
					if (digest_fire) begin
						out_idx_q <= out_idx_q + 3'd1;
						if (out_idx_q == 3'd7) begin
							// drop back to the initial hash for the next message
							h_q       <= H_INIT;
							count_q   <= 61'd0;
							end_q     <= 1'b0;
							done_q    <= 1'b0;
							pad_q     <= P_MARK;
							len_idx_q <= 3'd0;
							state_q   <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/sha256mh_checker.sv -----
// Port-level checks for the SHA-256 message hasher core, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "sha256_message_hasher_core_assert.svh"
module sha256mh_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_ready,
	input  logic        digest_valid,
	input  logic        digest_ready,
	input  logic [31:0] digest_word,
	input  logic [2:0]  word_index,
	input  logic        last_word
);

	// Never take a new item while a digest beat is on offer.
	`SMH_ASSERT_NOW(a_no_overlap, clk, arst_n, digest_valid, !item_ready)

	`SMH_ASSERT_NOW(a_last_on_word7, clk, arst_n, digest_valid, last_word == (word_index == 3'd7))

	// Digest beats follow one another in word order without gaps.
	`SMH_ASSERT_NEXT(a_word_order, clk, arst_n, digest_valid && digest_ready && !last_word, digest_valid && (word_index == 3'($past(word_index) + 3'd1)))

	`SMH_ASSERT_NEXT(a_idle_after_last, clk, arst_n, digest_valid && digest_ready && last_word, item_ready && !digest_valid)

	`SMH_ASSERT_NEXT(a_beat_holds, clk, arst_n, digest_valid && !digest_ready, digest_valid && $stable(digest_word) && $stable(word_index))

endmodule

bind sha256_message_hasher_core sha256mh_checker u_sha256mh_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_ready   (item_ready),
	.digest_valid (digest_valid),
	.digest_ready (digest_ready),
	.digest_word  (digest_word),
	.word_index   (word_index),
	.last_word    (last_word)
);
`default_nettype wire
